[rtl/psat_pkg.sv]
// Shared types, widths and helpers for the per-id score accumulator table.
// No dependencies; imported by psat_cell and per_id_score_accumulator_table.
package psat_pkg;

    localparam int KEY_W    = 22;
    localparam int AMT_W    = 16;
    localparam int SCORE_W  = 32;

    localparam int DEF_TABLE_DEPTH = 128;

    localparam logic signed [SCORE_W-1:0] THRESHOLD_RESET = 32'sd80;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Request travelling along the row of cells
    typedef struct packed {
        logic                      vld;
        logic                      cmd;
        logic [KEY_W-1:0]          key;
        logic signed [AMT_W-1:0]   amount;
        logic                      done;
        logic signed [SCORE_W-1:0] score;
        logic                      created;
    } tok_t;

    // Saturating add of a 16-bit increment to a 32-bit score
    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [AMT_W-1:0]   b
    );
        logic [SCORE_W:0] sum;
        logic [SCORE_W:0] a_ext;
        logic [SCORE_W:0] b_ext;
        begin
            a_ext = {a[SCORE_W-1], a};
            b_ext = {{(SCORE_W-AMT_W+1){b[AMT_W-1]}}, b};
            sum   = a_ext + b_ext;
            if (sum[SCORE_W] != sum[SCORE_W-1])
            begin
                sat_add = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                       : {1'b0, {(SCORE_W-1){1'b1}}};
            end
            else
            begin
                sat_add = sum[SCORE_W-1:0];
            end
        end
    endfunction

endpackage

[rtl/psat_cell.sv]
// One table entry (key and score) with its stage of the request chain.
// Depends on psat_pkg for the request type and the saturating add.
module psat_cell #(
    parameter int TableDepth = 128,
    parameter int Idx        = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic [$clog2(TableDepth+1)-1:0]     used_cnt,
    input  psat_pkg::tok_t                      tok_i,
    output psat_pkg::tok_t                      tok_o
);
    import psat_pkg::*;

    localparam int CntW = $clog2(TableDepth + 1);
    localparam logic [CntW-1:0] IdxC = CntW'(Idx);

    logic [KEY_W-1:0]          key_reg;
    logic [KEY_W-1:0]          key_next;
    logic signed [SCORE_W-1:0] score_reg;
    logic signed [SCORE_W-1:0] score_next;
    tok_t                      tok_reg;
    tok_t                      tok_next;

    logic                      live;
    logic                      hit;
    logic                      claim;
    logic signed [SCORE_W-1:0] base;
    logic signed [SCORE_W-1:0] upd;

    always_comb
    begin
        live  = tok_i.vld && !tok_i.done;
        hit   = live && (IdxC < used_cnt) && (key_reg == tok_i.key);
        claim = live && (IdxC == used_cnt);
        base  = hit ? score_reg : '0;
        upd   = (tok_i.cmd == CMD_CLEAR) ? '0 : sat_add(base, tok_i.amount);

        key_next   = key_reg;
        score_next = score_reg;
        tok_next   = tok_i;
        if (hit || claim)
        begin
            score_next       = upd;
            tok_next.done    = 1'b1;
            tok_next.score   = upd;
            tok_next.created = claim;
        end
        if (claim)
        begin
            key_next = tok_i.key;
        end
    end

    // entry storage: written before it is ever compared
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg   <= key_next;
            score_reg <= score_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

[rtl/per_id_score_accumulator_table.sv]
// Top level of the per-id score accumulator table: a row of entry cells
// that a request walks through. Depends on psat_pkg and psat_cell.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_ready, command, process_id,        | to block
//          | add_amount                                      |
//  out     | out_valid, out_ready, score_now, over_threshold,| from block
//          | entry_created, table_full                       |
//  cfg     | cfg_valid, cfg_ready, cfg_data (score threshold)| to block
//
// An accepted beat enters a request register, then moves one cell per cycle
// along TABLE_DEPTH cells while the row is not held, and the last cell's
// result is registered at the output; one request is in the row at a time,
// so no new beat is taken until the previous one has left the row.
// The first cell holding the key applies the command; failing that the first
// free cell (index equal to the fill count) claims the key.
// A stalled output register holds the whole row; the next beat is accepted
// as soon as the result has left the row, even if it still waits at out.
// Reset clears the fill count, the row's request registers and sets the
// threshold to 80; entry contents need no clearing.
module per_id_score_accumulator_table #(
    parameter int TABLE_DEPTH = psat_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic [psat_pkg::KEY_W-1:0]           process_id,
    input  logic signed [psat_pkg::AMT_W-1:0]    add_amount,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [psat_pkg::SCORE_W-1:0]  score_now,
    output logic                                 over_threshold,
    output logic                                 entry_created,
    output logic                                 table_full,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic signed [psat_pkg::SCORE_W-1:0]  cfg_data
);
    import psat_pkg::*;

    localparam int CntW = $clog2(TABLE_DEPTH + 1);

    tok_t                      chain [TABLE_DEPTH+1];
    tok_t                      tok_in_reg;
    tok_t                      tok_in_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic [CntW-1:0]           used_reg;
    logic [CntW-1:0]           used_next;
    logic signed [SCORE_W-1:0] thr_reg;
    logic                      out_vld_reg;
    logic                      out_vld_next;
    logic signed [SCORE_W-1:0] score_reg;
    logic                      over_reg;
    logic                      created_reg;
    logic                      full_reg;

    logic                      adv;
    logic                      acc;
    logic                      leave;
    tok_t                      tail;
    logic signed [SCORE_W-1:0] tail_score;

    // hold the row while a finished result cannot move on
    assign adv       = !(out_vld_reg && !out_ready);
    assign acc       = in_valid && in_ready;
    assign in_ready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign tail      = chain[TABLE_DEPTH];
    assign leave     = tail.vld && adv;
    assign tail_score = tail.done ? tail.score : '0;

    always_comb
    begin
        tok_in_next = tok_in_reg;
        if (acc)
        begin
            tok_in_next.vld     = 1'b1;
            tok_in_next.cmd     = command;
            tok_in_next.key     = process_id;
            tok_in_next.amount  = add_amount;
            tok_in_next.done    = 1'b0;
            tok_in_next.score   = '0;
            tok_in_next.created = 1'b0;
        end
        else if (adv)
        begin
            tok_in_next.vld = 1'b0;
        end

        busy_next = busy_reg;
        if (acc)
        begin
            busy_next = 1'b1;
        end
        else if (leave)
        begin
            busy_next = 1'b0;
        end

        used_next = used_reg;
        if (leave && tail.created)
        begin
            used_next = used_reg + CntW'(1);
        end

        out_vld_next = out_vld_reg;
        if (leave)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    assign chain[0] = tok_in_reg;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        psat_cell #(
            .TableDepth (TABLE_DEPTH),
            .Idx        (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .used_cnt (used_reg),
            .tok_i    (chain[g]),
            .tok_o    (chain[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_in_reg  <= '0;
            busy_reg    <= 1'b0;
            used_reg    <= '0;
            out_vld_reg <= 1'b0;
            thr_reg     <= THRESHOLD_RESET;
        end
        else
        begin
            tok_in_reg  <= tok_in_next;
            busy_reg    <= busy_next;
            used_reg    <= used_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // result payload: a request that found no home reports a full table
    always_ff @(posedge clk)
    begin
        if (leave)
        begin
            score_reg   <= tail_score;
            over_reg    <= (tail_score >= thr_reg);
            created_reg <= tail.created;
            full_reg    <= !tail.done;
        end
    end

    assign out_valid      = out_vld_reg;
    assign score_now      = score_reg;
    assign over_threshold = over_reg;
    assign entry_created  = created_reg;
    assign table_full     = full_reg;

endmodule
